// ===== hdl/bcss_pkg.sv =====
`default_nettype none

package bcss_pkg;

  localparam int NUM_DOTS   = 6;
  localparam int TIMER_W    = 24;
  localparam int CNT_W      = $clog2(NUM_DOTS + 1);
  localparam int PERIOD_W   = 16;
  localparam int PPC_W      = 8;
  localparam int THR_W      = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int PHASE_W    = 3;
  localparam int UADDR_W    = 6;

  localparam logic [NUM_DOTS-1:0] DOT_MASK  = {NUM_DOTS{1'b1}};
  localparam logic [TIMER_W-1:0]  TIMER_MAX = {TIMER_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RETRACT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_POP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POP_PER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_ON     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STAGGER    = 3'd7;

  localparam logic [23:0]         RST_RETRACT    = 24'd100000;
  localparam logic [23:0]         RST_FIRST_POP  = 24'd120000;
  localparam logic [PPC_W-1:0]    RST_POP_PER    = 8'd30;
  localparam logic [PERIOD_W-1:0] RST_PWM_PERIOD = 16'd4000;
  localparam logic [PERIOD_W-1:0] RST_PWM_ON     = 16'd3000;
  localparam logic [23:0]         RST_HOLD       = 24'd2000000;
  localparam logic [23:0]         RST_BLANK      = 24'd2000000;
  localparam logic [THR_W-1:0]    RST_STAGGER    = 3'd3;

  // phase codes as shown on the result channel
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRE   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_POP   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HOLD  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_POST  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BLANK = 3'd5;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_DRIVE    = 4'd1,
    OP_REJECT   = 4'd2,
    OP_LOAD     = 4'd3,
    OP_SLOT_SET = 4'd4,
    OP_TINC     = 4'd5,
    OP_TCLR     = 4'd6,
    OP_IDLE     = 4'd7,
    OP_TO_BLANK = 4'd8,
    OP_TO_POP   = 4'd9,
    OP_NEXT_POP = 4'd10,
    OP_PPC_INC  = 4'd11,
    OP_HOLD_INC = 4'd12,
    OP_SLOT_ADV = 4'd13,
    OP_TO_POST  = 4'd14,
    OP_PUBLISH  = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    LIM_RETRACT = 3'd0,
    LIM_FIRST   = 3'd1,
    LIM_PERIOD  = 3'd2,
    LIM_SLOT    = 3'd3,
    LIM_BLANK   = 3'd4
  } lim_t;

  typedef enum logic [4:0] {
    C_NEVER      = 5'd0,
    C_ALWAYS     = 5'd1,
    C_OUT_FULL   = 5'd2,
    C_LOAD       = 5'd3,
    C_PH_PRE     = 5'd4,
    C_PH_POP     = 5'd5,
    C_PH_HOLD    = 5'd6,
    C_PH_POST    = 5'd7,
    C_PH_BLANK   = 5'd8,
    C_NSPAN      = 5'd9,
    C_CNT_ZERO   = 5'd10,
    C_BLANK_ZERO = 5'd11,
    C_POP_FIRST  = 5'd12,
    C_PPC_LAST   = 5'd13,
    C_STAGGER    = 5'd14,
    C_SLOT_LAST  = 5'd15,
    C_HOLD_EXIT  = 5'd16,
    C_BUSY       = 5'd17,
    C_DIV_BUSY   = 5'd18
  } cond_t;

  typedef struct packed {
    op_t                op;
    lim_t               lim;
    cond_t              cond;
    logic [UADDR_W-1:0] target;
    logic               fin;
    logic               last;
  } uword_t;

  typedef struct packed {
    op_t  op;
    lim_t lim;
  } ctrl_t;

  typedef struct packed {
    logic load;
    logic ph_pre;
    logic ph_pop;
    logic ph_hold;
    logic ph_post;
    logic ph_blank;
    logic nspan;
    logic cnt_zero;
    logic blank_zero;
    logic pop_first;
    logic ppc_last;
    logic stagger;
    logic slot_last;
    logic hold_exit;
    logic busy;
    logic div_busy;
  } flags_t;

  // microprogram entry points
  localparam logic [UADDR_W-1:0] A_WAIT    = 6'd0;
  localparam logic [UADDR_W-1:0] A_TYPE    = 6'd1;
  localparam logic [UADDR_W-1:0] A_TICK    = 6'd2;
  localparam logic [UADDR_W-1:0] A_DSP_POP = 6'd3;
  localparam logic [UADDR_W-1:0] A_DSP_HLD = 6'd4;
  localparam logic [UADDR_W-1:0] A_DSP_PST = 6'd5;
  localparam logic [UADDR_W-1:0] A_DSP_BLK = 6'd6;
  localparam logic [UADDR_W-1:0] A_SETIDLE = 6'd7;
  localparam logic [UADDR_W-1:0] A_PRE     = 6'd8;
  localparam logic [UADDR_W-1:0] A_PRE_END = 6'd9;
  localparam logic [UADDR_W-1:0] A_PRE_POP = 6'd10;
  localparam logic [UADDR_W-1:0] A_EMPTY   = 6'd11;
  localparam logic [UADDR_W-1:0] A_TOBLANK = 6'd12;
  localparam logic [UADDR_W-1:0] A_BLANK   = 6'd13;
  localparam logic [UADDR_W-1:0] A_BLK_END = 6'd14;
  localparam logic [UADDR_W-1:0] A_POP     = 6'd15;
  localparam logic [UADDR_W-1:0] A_POP_PER = 6'd16;
  localparam logic [UADDR_W-1:0] A_POP_CNT = 6'd17;
  localparam logic [UADDR_W-1:0] A_PPC_INC = 6'd18;
  localparam logic [UADDR_W-1:0] A_POPF    = 6'd19;
  localparam logic [UADDR_W-1:0] A_NEXTPOP = 6'd20;
  localparam logic [UADDR_W-1:0] A_HOLD    = 6'd21;
  localparam logic [UADDR_W-1:0] A_HLD_PER = 6'd22;
  localparam logic [UADDR_W-1:0] A_HLD_CLR = 6'd23;
  localparam logic [UADDR_W-1:0] A_STAG    = 6'd24;
  localparam logic [UADDR_W-1:0] A_SLOTADV = 6'd25;
  localparam logic [UADDR_W-1:0] A_BND     = 6'd26;
  localparam logic [UADDR_W-1:0] A_TOPOST  = 6'd27;
  localparam logic [UADDR_W-1:0] A_POST    = 6'd28;
  localparam logic [UADDR_W-1:0] A_PST_END = 6'd29;
  localparam logic [UADDR_W-1:0] A_INC     = 6'd30;
  localparam logic [UADDR_W-1:0] A_LOAD    = 6'd31;
  localparam logic [UADDR_W-1:0] A_LATCH   = 6'd32;
  localparam logic [UADDR_W-1:0] A_DIVW    = 6'd33;
  localparam logic [UADDR_W-1:0] A_SLOTSET = 6'd34;
  localparam logic [UADDR_W-1:0] A_LDDRV   = 6'd35;
  localparam logic [UADDR_W-1:0] A_REJ     = 6'd36;
  localparam logic [UADDR_W-1:0] A_DONE    = 6'd37;

  function automatic uword_t uw(op_t op, lim_t lim, cond_t cond,
                                logic [UADDR_W-1:0] target, logic fin, logic last);
    uword_t w;
    w.op     = op;
    w.lim    = lim;
    w.cond   = cond;
    w.target = target;
    w.fin    = fin;
    w.last   = last;
    return w;
  endfunction

  // fin: go to the publish step when the jump is not taken
  function automatic uword_t ucode_rom(logic [UADDR_W-1:0] addr);
    uword_t w;
    unique case (addr)
      A_WAIT:    w = uw(OP_NOP,      LIM_RETRACT, C_OUT_FULL,   A_WAIT,    1'b0, 1'b0);
      A_TYPE:    w = uw(OP_NOP,      LIM_RETRACT, C_LOAD,       A_LOAD,    1'b0, 1'b0);
      A_TICK:    w = uw(OP_DRIVE,    LIM_RETRACT, C_PH_PRE,     A_PRE,     1'b0, 1'b0);
      A_DSP_POP: w = uw(OP_NOP,      LIM_RETRACT, C_PH_POP,     A_POP,     1'b0, 1'b0);
      A_DSP_HLD: w = uw(OP_NOP,      LIM_RETRACT, C_PH_HOLD,    A_HOLD,    1'b0, 1'b0);
      A_DSP_PST: w = uw(OP_NOP,      LIM_RETRACT, C_PH_POST,    A_POST,    1'b0, 1'b0);
      A_DSP_BLK: w = uw(OP_NOP,      LIM_RETRACT, C_PH_BLANK,   A_BLANK,   1'b0, 1'b0);
      A_SETIDLE: w = uw(OP_IDLE,     LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_PRE:     w = uw(OP_NOP,      LIM_RETRACT, C_NSPAN,      A_INC,     1'b0, 1'b0);
      A_PRE_END: w = uw(OP_TCLR,     LIM_RETRACT, C_CNT_ZERO,   A_EMPTY,   1'b0, 1'b0);
      A_PRE_POP: w = uw(OP_TO_POP,   LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_EMPTY:   w = uw(OP_NOP,      LIM_RETRACT, C_BLANK_ZERO, A_SETIDLE, 1'b0, 1'b0);
      A_TOBLANK: w = uw(OP_TO_BLANK, LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_BLANK:   w = uw(OP_NOP,      LIM_BLANK,   C_NSPAN,      A_INC,     1'b0, 1'b0);
      A_BLK_END: w = uw(OP_IDLE,     LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_POP:     w = uw(OP_NOP,      LIM_RETRACT, C_POP_FIRST,  A_POPF,    1'b0, 1'b0);
      A_POP_PER: w = uw(OP_NOP,      LIM_PERIOD,  C_NSPAN,      A_INC,     1'b0, 1'b0);
      A_POP_CNT: w = uw(OP_NOP,      LIM_RETRACT, C_PPC_LAST,   A_NEXTPOP, 1'b0, 1'b0);
      A_PPC_INC: w = uw(OP_PPC_INC,  LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_POPF:    w = uw(OP_NOP,      LIM_FIRST,   C_NSPAN,      A_INC,     1'b0, 1'b0);
      A_NEXTPOP: w = uw(OP_NEXT_POP, LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_HOLD:    w = uw(OP_HOLD_INC, LIM_RETRACT, C_STAGGER,    A_STAG,    1'b0, 1'b0);
      A_HLD_PER: w = uw(OP_NOP,      LIM_PERIOD,  C_NSPAN,      A_INC,     1'b0, 1'b0);
      A_HLD_CLR: w = uw(OP_TCLR,     LIM_RETRACT, C_ALWAYS,     A_BND,     1'b0, 1'b0);
      A_STAG:    w = uw(OP_NOP,      LIM_SLOT,    C_NSPAN,      A_INC,     1'b0, 1'b0);
      A_SLOTADV: w = uw(OP_SLOT_ADV, LIM_RETRACT, C_SLOT_LAST,  A_BND,     1'b1, 1'b0);
      A_BND:     w = uw(OP_NOP,      LIM_RETRACT, C_HOLD_EXIT,  A_TOPOST,  1'b1, 1'b0);
      A_TOPOST:  w = uw(OP_TO_POST,  LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_POST:    w = uw(OP_NOP,      LIM_RETRACT, C_NSPAN,      A_INC,     1'b0, 1'b0);
      A_PST_END: w = uw(OP_IDLE,     LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_INC:     w = uw(OP_TINC,     LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_LOAD:    w = uw(OP_NOP,      LIM_RETRACT, C_BUSY,       A_REJ,     1'b0, 1'b0);
      A_LATCH:   w = uw(OP_LOAD,     LIM_RETRACT, C_NEVER,      A_WAIT,    1'b0, 1'b0);
      A_DIVW:    w = uw(OP_NOP,      LIM_RETRACT, C_DIV_BUSY,   A_DIVW,    1'b0, 1'b0);
      A_SLOTSET: w = uw(OP_SLOT_SET, LIM_RETRACT, C_NEVER,      A_WAIT,    1'b0, 1'b0);
      A_LDDRV:   w = uw(OP_DRIVE,    LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_REJ:     w = uw(OP_REJECT,   LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
      A_DONE:    w = uw(OP_PUBLISH,  LIM_RETRACT, C_NEVER,      A_WAIT,    1'b0, 1'b1);
      default:   w = uw(OP_NOP,      LIM_RETRACT, C_NEVER,      A_WAIT,    1'b1, 1'b0);
    endcase
    return w;
  endfunction

  // mask of the first n set dots of a pattern
  function automatic logic [NUM_DOTS-1:0] first_dots(logic [NUM_DOTS-1:0] pat,
                                                     logic [CNT_W:0] n);
    logic [NUM_DOTS-1:0] m;
    logic [CNT_W:0]      seen;
    m    = '0;
    seen = '0;
    for (int k = 0; k < NUM_DOTS; k++) begin
      if (pat[k] && (seen < n)) begin
        m[k] = 1'b1;
        seen = seen + 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic [NUM_DOTS-1:0] nth_dot(logic [NUM_DOTS-1:0] pat,
                                                  logic [CNT_W-1:0] n);
    logic [CNT_W:0] nn;
    nn = {1'b0, n};
    return first_dots(pat, nn + 1'b1) & ~first_dots(pat, nn);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bcss_div.sv =====
`default_nettype none

module bcss_div
  import bcss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [PERIOD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]    divisor,
  output logic                     busy,
  output logic [PERIOD_W-1:0]      quotient
);

  localparam int ITER_W = $clog2(PERIOD_W + 1);

  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic [CNT_W:0]      rem_r, rem_nxt;
  logic [PERIOD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]    dvs_r;
  logic [CNT_W:0]      trial;

  // one restoring step per cycle; the dividend shifts out of quo_r as quotient bits shift in
  always_comb begin
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r[CNT_W-1:0], quo_r[PERIOD_W-1]};
    if (start) begin
      iter_nxt = ITER_W'(PERIOD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (iter_r != '0) begin
      iter_nxt = iter_r - 1'b1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[PERIOD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[PERIOD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else begin
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign busy     = (iter_r != '0);
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== hdl/bcss_seq.sv =====
`default_nettype none

module bcss_seq
  import bcss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire logic   out_full,
  input  wire flags_t flags,
  output ctrl_t       ctrl,
  output logic        running
);

  logic               run_r, run_nxt;
  logic [UADDR_W-1:0] upc_r, upc_nxt;
  uword_t             word;
  logic               taken;

  assign word = ucode_rom(upc_r);

  always_comb begin
    unique case (word.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_OUT_FULL:   taken = out_full;
      C_LOAD:       taken = flags.load;
      C_PH_PRE:     taken = flags.ph_pre;
      C_PH_POP:     taken = flags.ph_pop;
      C_PH_HOLD:    taken = flags.ph_hold;
      C_PH_POST:    taken = flags.ph_post;
      C_PH_BLANK:   taken = flags.ph_blank;
      C_NSPAN:      taken = flags.nspan;
      C_CNT_ZERO:   taken = flags.cnt_zero;
      C_BLANK_ZERO: taken = flags.blank_zero;
      C_POP_FIRST:  taken = flags.pop_first;
      C_PPC_LAST:   taken = flags.ppc_last;
      C_STAGGER:    taken = flags.stagger;
      C_SLOT_LAST:  taken = flags.slot_last;
      C_HOLD_EXIT:  taken = flags.hold_exit;
      C_BUSY:       taken = flags.busy;
      C_DIV_BUSY:   taken = flags.div_busy;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    run_nxt = run_r;
    upc_nxt = upc_r;
    if (!run_r) begin
      if (start) begin
        run_nxt = 1'b1;
        upc_nxt = A_WAIT;
      end
    end else if (taken) begin
      upc_nxt = word.target;
    end else if (word.fin) begin
      upc_nxt = A_DONE;
    end else if (word.last) begin
      run_nxt = 1'b0;
      upc_nxt = A_WAIT;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      upc_r <= A_WAIT;
    end else begin
      run_r <= run_nxt;
      upc_r <= upc_nxt;
    end
  end

  // ops fire only while a request is in progress
  assign ctrl.op  = run_r ? word.op : OP_NOP;
  assign ctrl.lim = word.lim;
  assign running  = run_r;

endmodule

`default_nettype wire

// ===== hdl/bcss_datapath.sv =====
`default_nettype none

module bcss_datapath
  import bcss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  capture,
  input  wire logic                  in_mode,
  input  wire logic [NUM_DOTS-1:0]   in_pattern,
  input  wire logic                  in_abort,
  input  wire ctrl_t                 ctrl,
  output flags_t                     flags,
  output logic [NUM_DOTS-1:0]        drive_hi,
  output logic [NUM_DOTS-1:0]        drive_lo,
  output logic [PHASE_W-1:0]         phase
);

  // configuration
  logic [23:0]         retract_r, first_pop_r, hold_r, blank_r;
  logic [PPC_W-1:0]    pop_per_r;
  logic [PERIOD_W-1:0] period_r, on_r;
  logic [THR_W-1:0]    stagger_r;

  // request holding registers
  logic                mode_r, abort_r;
  logic [NUM_DOTS-1:0] pat_in_r;

  // sequence state
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [NUM_DOTS-1:0] pat_r, pat_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TIMER_W-1:0]  timer_r, timer_nxt;
  logic [TIMER_W-1:0]  hold_el_r, hold_el_nxt;
  logic [CNT_W-1:0]    pop_r, pop_nxt;
  logic [PPC_W-1:0]    ppc_r, ppc_nxt;
  logic [CNT_W-1:0]    slot_r, slot_nxt;
  logic [PERIOD_W-1:0] slot_len_r, slot_len_nxt;

  logic [CNT_W-1:0]    in_cnt;
  logic                div_start, div_busy;
  logic [PERIOD_W-1:0] div_q;
  logic [TIMER_W:0]    tnext, lim_v;
  logic [CNT_W-1:0]    pop_inc;

  always_comb begin
    in_cnt = '0;
    for (int k = 0; k < NUM_DOTS; k++) begin
      in_cnt = in_cnt + CNT_W'(pat_in_r[k]);
    end
  end

  assign div_start = (ctrl.op == OP_LOAD);

  bcss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (period_r),
    .divisor  (in_cnt),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retract_r   <= RST_RETRACT;
      first_pop_r <= RST_FIRST_POP;
      pop_per_r   <= RST_POP_PER;
      period_r    <= RST_PWM_PERIOD;
      on_r        <= RST_PWM_ON;
      hold_r      <= RST_HOLD;
      blank_r     <= RST_BLANK;
      stagger_r   <= RST_STAGGER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RETRACT:    retract_r   <= cfg_data[23:0];
        REG_FIRST_POP:  first_pop_r <= cfg_data[23:0];
        REG_POP_PER:    pop_per_r   <= cfg_data[PPC_W-1:0];
        REG_PWM_PERIOD: period_r    <= cfg_data[PERIOD_W-1:0];
        REG_PWM_ON:     on_r        <= cfg_data[PERIOD_W-1:0];
        REG_HOLD:       hold_r      <= cfg_data[23:0];
        REG_BLANK:      blank_r     <= cfg_data[23:0];
        REG_STAGGER:    stagger_r   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      mode_r   <= in_mode;
      pat_in_r <= in_pattern;
      abort_r  <= in_abort;
    end
  end

  // span limit for the timer compare, selected by the control word
  always_comb begin
    unique case (ctrl.lim)
      LIM_RETRACT: lim_v = (TIMER_W+1)'(retract_r);
      LIM_FIRST:   lim_v = (TIMER_W+1)'(first_pop_r);
      LIM_PERIOD:  lim_v = (TIMER_W+1)'(period_r);
      LIM_SLOT:    lim_v = (TIMER_W+1)'(slot_len_r);
      LIM_BLANK:   lim_v = (TIMER_W+1)'(blank_r);
      default:     lim_v = (TIMER_W+1)'(retract_r);
    endcase
  end

  assign tnext   = {1'b0, timer_r} + 1'b1;
  assign pop_inc = pop_r + 1'b1;

  always_comb begin
    flags.load       = mode_r;
    flags.ph_pre     = (phase_r == PH_PRE);
    flags.ph_pop     = (phase_r == PH_POP);
    flags.ph_hold    = (phase_r == PH_HOLD);
    flags.ph_post    = (phase_r == PH_POST);
    flags.ph_blank   = (phase_r == PH_BLANK);
    flags.nspan      = !((tnext >= lim_v) || (tnext >= {1'b0, TIMER_MAX}));
    flags.cnt_zero   = (cnt_r == '0);
    flags.blank_zero = (blank_r == '0);
    flags.pop_first  = (pop_r == '0);
    flags.ppc_last   = (({1'b0, ppc_r} + 1'b1) >= {1'b0, pop_per_r});
    flags.stagger    = ({1'b0, cnt_r} > {1'b0, stagger_r});
    flags.slot_last  = (({1'b0, slot_r} + 1'b1) >= {1'b0, cnt_r});
    flags.hold_exit  = abort_r || (hold_el_r >= TIMER_W'(hold_r));
    flags.busy       = (phase_r != PH_IDLE);
    flags.div_busy   = div_busy;
  end

  always_comb begin
    drive_hi = '0;
    drive_lo = '0;
    case (phase_r)
      PH_PRE, PH_POST: drive_lo = DOT_MASK;
      PH_POP: begin
        if (pop_r == '0) begin
          drive_hi = nth_dot(pat_r, '0);
        end else if (timer_r < TIMER_W'(on_r)) begin
          drive_hi = first_dots(pat_r, {1'b0, pop_r} + 1'b1);
        end else begin
          drive_hi = nth_dot(pat_r, pop_r);
        end
      end
      PH_HOLD: begin
        if (flags.stagger) begin
          drive_hi = pat_r & ~nth_dot(pat_r, slot_r);
        end else if (timer_r < TIMER_W'(on_r)) begin
          drive_hi = pat_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    pat_nxt      = pat_r;
    cnt_nxt      = cnt_r;
    timer_nxt    = timer_r;
    hold_el_nxt  = hold_el_r;
    pop_nxt      = pop_r;
    ppc_nxt      = ppc_r;
    slot_nxt     = slot_r;
    slot_len_nxt = slot_len_r;
    case (ctrl.op)
      OP_LOAD: begin
        pat_nxt     = pat_in_r;
        cnt_nxt     = in_cnt;
        phase_nxt   = PH_PRE;
        timer_nxt   = '0;
        hold_el_nxt = '0;
        pop_nxt     = '0;
        ppc_nxt     = '0;
        slot_nxt    = '0;
      end
      OP_SLOT_SET: begin
        slot_len_nxt = ((div_q == '0) || (cnt_r == '0)) ? PERIOD_W'(1) : div_q;
      end
      OP_TINC: timer_nxt = timer_r + 1'b1;
      OP_TCLR: timer_nxt = '0;
      OP_IDLE: begin
        phase_nxt = PH_IDLE;
        timer_nxt = '0;
      end
      OP_TO_BLANK: phase_nxt = PH_BLANK;
      OP_TO_POP: begin
        phase_nxt = PH_POP;
        pop_nxt   = '0;
        ppc_nxt   = '0;
      end
      OP_NEXT_POP: begin
        timer_nxt = '0;
        ppc_nxt   = '0;
        pop_nxt   = pop_inc;
        if (pop_inc >= cnt_r) begin
          phase_nxt   = PH_HOLD;
          hold_el_nxt = '0;
          slot_nxt    = '0;
        end
      end
      OP_PPC_INC: begin
        timer_nxt = '0;
        ppc_nxt   = ppc_r + 1'b1;
      end
      OP_HOLD_INC: begin
        if (hold_el_r < TIMER_MAX) begin
          hold_el_nxt = hold_el_r + 1'b1;
        end
      end
      OP_SLOT_ADV: begin
        timer_nxt = '0;
        slot_nxt  = flags.slot_last ? '0 : slot_r + 1'b1;
      end
      OP_TO_POST: begin
        phase_nxt = PH_POST;
        timer_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pat_r      <= '0;
      cnt_r      <= '0;
      timer_r    <= '0;
      hold_el_r  <= '0;
      pop_r      <= '0;
      ppc_r      <= '0;
      slot_r     <= '0;
      slot_len_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pat_r      <= pat_nxt;
      cnt_r      <= cnt_nxt;
      timer_r    <= timer_nxt;
      hold_el_r  <= hold_el_nxt;
      pop_r      <= pop_nxt;
      ppc_r      <= ppc_nxt;
      slot_r     <= slot_nxt;
      slot_len_r <= slot_len_nxt;
    end
  end

  assign phase = phase_r;

endmodule

`default_nettype wire

// ===== hdl/braille_cell_solenoid_sequencer_core.sv =====
`default_nettype none
// Channel   Handshake            Payload
// in        in_valid / in_stall  in_mode, in_pattern, in_abort_request
// out       out_valid/ out_stall out_high_side_mask, out_low_side_mask, out_busy_res,
//                                out_phase, out_load_rejected
// cfg       cfg_we               cfg_index, cfg_data (write only)
//
// One request at a time, run by a microprogram at one control word per cycle.
// The path from accept to a tick's result is set by the dispatch path length for its phase.
// A load waits on the 16-step serial slot-length divider before its result;
// a rejected load skips the divider.
// Reset is synchronous; the output register holds a result under out_stall while the next
// request is accepted, and the program waits before its drive step until that slot frees.

module braille_cell_solenoid_sequencer_core
  import bcss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [NUM_DOTS-1:0]   in_pattern,
  input  wire logic                  in_abort_request,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [NUM_DOTS-1:0]        out_high_side_mask,
  output logic [NUM_DOTS-1:0]        out_low_side_mask,
  output logic                       out_busy_res,
  output logic [PHASE_W-1:0]         out_phase,
  output logic                       out_load_rejected,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic                running, accept, out_full;
  ctrl_t               ctrl;
  flags_t              flags;
  logic [NUM_DOTS-1:0] drive_hi, drive_lo;
  logic [PHASE_W-1:0]  phase;

  logic                out_valid_r, out_valid_nxt;
  logic [NUM_DOTS-1:0] hi_r, lo_r;
  logic                busy_r, rej_r;
  logic [PHASE_W-1:0]  phase_out_r;

  assign in_stall = running;
  assign accept   = in_valid && !running;
  assign out_full = out_valid_r && out_stall;

  bcss_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .out_full (out_full),
    .flags    (flags),
    .ctrl     (ctrl),
    .running  (running)
  );

  bcss_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .capture    (accept),
    .in_mode    (in_mode),
    .in_pattern (in_pattern),
    .in_abort   (in_abort_request),
    .ctrl       (ctrl),
    .flags      (flags),
    .drive_hi   (drive_hi),
    .drive_lo   (drive_lo),
    .phase      (phase)
  );

  assign out_valid_nxt = (ctrl.op == OP_PUBLISH) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // a tick's drive is sampled before the state advances, a load's after it; phase after both
  always_ff @(posedge clk) begin
    if ((ctrl.op == OP_DRIVE) || (ctrl.op == OP_REJECT)) begin
      hi_r  <= drive_hi;
      lo_r  <= drive_lo;
      rej_r <= (ctrl.op == OP_REJECT);
    end
    if (ctrl.op == OP_PUBLISH) begin
      phase_out_r <= phase;
      busy_r      <= (phase != PH_IDLE);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_high_side_mask = hi_r;
  assign out_low_side_mask  = lo_r;
  assign out_busy_res       = busy_r;
  assign out_phase          = phase_out_r;
  assign out_load_rejected  = rej_r;

endmodule

`default_nettype wire

// ===== hdl/bcss_checker.sv =====
`default_nettype none

module bcss_checker
  import bcss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [NUM_DOTS-1:0]   out_high_side_mask,
  input  wire logic [NUM_DOTS-1:0]   out_low_side_mask,
  input  wire logic                  out_busy_res,
  input  wire logic [PHASE_W-1:0]    out_phase,
  input  wire logic                  out_load_rejected
);

  // never raise and retract the same dot
  a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_high_side_mask & out_low_side_mask) == '0))
    else $error("bridge drives both sides of a dot");

  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_busy_res == (out_phase != PH_IDLE)))
    else $error("busy flag disagrees with phase");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_load_rejected) |-> out_busy_res)
    else $error("load rejected while idle");

  // a result in pre-retract always carries the full retract drive
  a_pre_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_phase == PH_PRE)) |->
      ((out_low_side_mask == DOT_MASK) && (out_high_side_mask == '0)))
    else $error("pre-retract result without retract drive");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without taking the channel");

endmodule

bind braille_cell_solenoid_sequencer_core bcss_checker u_bcss_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import bcss_pkg::*;

  localparam bit MODE_TICK = 1'b0;
  localparam bit MODE_LOAD = 1'b1;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [NUM_DOTS-1:0] high_side;
    logic [NUM_DOTS-1:0] low_side;
    logic                busy;
    logic [PHASE_W-1:0]  phase;
    logic                rejected;
  } bridge_drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = 1'b0;
  logic [NUM_DOTS-1:0]   in_pattern = '0;
  logic                  in_abort_request = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [NUM_DOTS-1:0]   out_high_side_mask;
  logic [NUM_DOTS-1:0]   out_low_side_mask;
  logic                  out_busy_res;
  logic [PHASE_W-1:0]    out_phase;
  logic                  out_load_rejected;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  braille_cell_solenoid_sequencer_core DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow registers and sequence state of the cell driver
  int unsigned retract_len, first_pop_len, pop_count_cfg, period_len, on_len;
  int unsigned hold_len, blank_len, stagger_cfg;
  logic [PHASE_W-1:0]  seq_phase;
  logic [NUM_DOTS-1:0] cell_dots;
  int unsigned dot_count, seq_timer, hold_time, pop_dot, pop_period_no, slot_dot, slot_len;

  bridge_drive_t pending_drive[$];
  int unsigned   err_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;
  int unsigned   stall_run = 0;
  int unsigned   stall_pct = 0;

  function automatic void restore_defaults();
    retract_len   = RST_RETRACT;
    first_pop_len = RST_FIRST_POP;
    pop_count_cfg = RST_POP_PER;
    period_len    = RST_PWM_PERIOD;
    on_len        = RST_PWM_ON;
    hold_len      = RST_HOLD;
    blank_len     = RST_BLANK;
    stagger_cfg   = RST_STAGGER;
    seq_phase     = PH_IDLE;
    cell_dots     = '0;
    dot_count     = 0;
    seq_timer     = 0;
    hold_time     = 0;
    pop_dot       = 0;
    pop_period_no = 0;
    slot_dot      = 0;
    slot_len      = 0;
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_RETRACT:    retract_len = v;
      REG_FIRST_POP:  first_pop_len = v;
      REG_POP_PER:    pop_count_cfg = v[7:0];
      REG_PWM_PERIOD: period_len = v[15:0];
      REG_PWM_ON:     on_len = v[15:0];
      REG_HOLD:       hold_len = v;
      REG_BLANK:      blank_len = v;
      REG_STAGGER:    stagger_cfg = v[2:0];
      default: ;
    endcase
  endfunction

  // the lowest n raised dots of the latched pattern
  function automatic logic [NUM_DOTS-1:0] leading_dots(int unsigned n);
    logic [NUM_DOTS-1:0] m;
    int unsigned         seen;
    m = '0;
    seen = 0;
    for (int k = 0; k < NUM_DOTS; k++) begin
      if (cell_dots[k] && seen < n) begin
        m[k] = 1'b1;
        seen++;
      end
    end
    return m;
  endfunction

  function automatic logic [NUM_DOTS-1:0] single_dot(int unsigned n);
    return leading_dots(n + 1) & ~leading_dots(n);
  endfunction

  function automatic bit span_over(int unsigned t, int unsigned lim);
    return (t + 1 >= lim) || (t + 1 >= TIMER_MAX);
  endfunction

  function automatic bridge_drive_t present_drive();
    bridge_drive_t d;
    d = '0;
    case (seq_phase)
      PH_PRE, PH_POST: d.low_side = DOT_MASK;
      PH_POP: begin
        if (pop_dot == 0) d.high_side = single_dot(0);
        else if (seq_timer < on_len) d.high_side = leading_dots(pop_dot + 1);
        else d.high_side = single_dot(pop_dot);
      end
      PH_HOLD: begin
        if (dot_count > stagger_cfg) d.high_side = cell_dots & ~single_dot(slot_dot);
        else if (seq_timer < on_len) d.high_side = cell_dots;
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic void enter_next_pop();
    seq_timer = 0;
    pop_period_no = 0;
    pop_dot = (pop_dot + 1) & 7;
    if (pop_dot >= dot_count) begin
      seq_phase = PH_HOLD;
      hold_time = 0;
      slot_dot = 0;
    end
  endfunction

  function automatic void advance_tick(bit abrt);
    bit boundary;
    boundary = 1'b0;
    case (seq_phase)
      PH_PRE: begin
        if (span_over(seq_timer, retract_len)) begin
          seq_timer = 0;
          if (dot_count == 0) begin
            seq_phase = (blank_len == 0) ? PH_IDLE : PH_BLANK;
          end else begin
            seq_phase = PH_POP;
            pop_dot = 0;
            pop_period_no = 0;
          end
        end else seq_timer++;
      end
      PH_BLANK: begin
        if (span_over(seq_timer, blank_len)) begin
          seq_timer = 0;
          seq_phase = PH_IDLE;
        end else seq_timer++;
      end
      PH_POP: begin
        if (pop_dot == 0) begin
          if (span_over(seq_timer, first_pop_len)) enter_next_pop();
          else seq_timer++;
        end else if (span_over(seq_timer, period_len)) begin
          seq_timer = 0;
          if (pop_period_no + 1 >= pop_count_cfg) enter_next_pop();
          else pop_period_no = (pop_period_no + 1) & 8'hFF;
        end else seq_timer++;
      end
      PH_HOLD: begin
        if (hold_time < TIMER_MAX) hold_time++;
        if (dot_count > stagger_cfg) begin
          if (span_over(seq_timer, slot_len)) begin
            seq_timer = 0;
            if (slot_dot + 1 >= dot_count) begin
              slot_dot = 0;
              boundary = 1'b1;
            end else slot_dot++;
          end else seq_timer++;
        end else if (span_over(seq_timer, period_len)) begin
          seq_timer = 0;
          boundary = 1'b1;
        end else seq_timer++;
        // the button only counts at the end of a full period, or of a full slot round when staggered
        if (boundary && (abrt || hold_time >= hold_len)) begin
          seq_phase = PH_POST;
          seq_timer = 0;
        end
      end
      PH_POST: begin
        if (span_over(seq_timer, retract_len)) begin
          seq_timer = 0;
          seq_phase = PH_IDLE;
        end else seq_timer++;
      end
      PH_IDLE: ;
      default: begin
        seq_phase = PH_IDLE;
        seq_timer = 0;
      end
    endcase
  endfunction

  function automatic bridge_drive_t predict_drive(bit mode, logic [NUM_DOTS-1:0] pat, bit abrt);
    bridge_drive_t d;
    bit            rej;
    rej = 1'b0;
    if (mode == MODE_LOAD) begin
      if (seq_phase != PH_IDLE) rej = 1'b1;
      else begin
        cell_dots = pat;
        dot_count = $countones(pat);
        slot_len = (dot_count != 0) ? period_len / dot_count : 0;
        if (slot_len == 0) slot_len = 1;
        seq_phase = PH_PRE;
        seq_timer = 0;
        hold_time = 0;
        pop_dot = 0;
        pop_period_no = 0;
        slot_dot = 0;
      end
      d = present_drive();
    end else begin
      d = present_drive();
      advance_tick(abrt);
    end
    d.busy = (seq_phase != PH_IDLE);
    d.phase = seq_phase;
    d.rejected = rej;
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("%0t ERROR: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_result
    bridge_drive_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_drive.pop_front();
        if (out_high_side_mask !== want.high_side)
          report_mismatch($sformatf("high side %b, want %b", out_high_side_mask, want.high_side));
        if (out_low_side_mask !== want.low_side)
          report_mismatch($sformatf("low side %b, want %b", out_low_side_mask, want.low_side));
        if (out_busy_res !== want.busy)
          report_mismatch($sformatf("busy %b, want %b", out_busy_res, want.busy));
        if (out_phase !== want.phase)
          report_mismatch($sformatf("phase %0d, want %0d", out_phase, want.phase));
        if (out_load_rejected !== want.rejected)
          report_mismatch($sformatf("load rejected %b, want %b",
                                    out_load_rejected, want.rejected));
      end
    end
  end

  // receiver stalls in runs of random length, each with its own density
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(8, 200);
      case ($urandom_range(4))
        0, 1: stall_pct = 0;
        2: stall_pct = 25;
        3: stall_pct = 60;
        default: stall_pct = 85;
      endcase
    end else stall_run--;
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_request(bit mode, logic [NUM_DOTS-1:0] pat, bit abrt);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_pattern <= pat;
    in_abort_request <= abrt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_drive.push_back(predict_drive(mode, pat, abrt));
    items_sent++;
  endtask

  // drop valid and let every outstanding request come back
  task automatic settle_block();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_drive.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle_block();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    shadow_write(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(logic [CFG_DATA_W-1:0] retract, logic [CFG_DATA_W-1:0] first_pop,
                            logic [CFG_DATA_W-1:0] pops, logic [CFG_DATA_W-1:0] period,
                            logic [CFG_DATA_W-1:0] on_t, logic [CFG_DATA_W-1:0] hold,
                            logic [CFG_DATA_W-1:0] blank, logic [CFG_DATA_W-1:0] stagger);
    write_reg(REG_RETRACT, retract);
    write_reg(REG_FIRST_POP, first_pop);
    write_reg(REG_POP_PER, pops);
    write_reg(REG_PWM_PERIOD, period);
    write_reg(REG_PWM_ON, on_t);
    write_reg(REG_HOLD, hold);
    write_reg(REG_BLANK, blank);
    write_reg(REG_STAGGER, stagger);
  endtask

  task automatic tick_run(int unsigned n, int unsigned abort_pct);
    repeat (n) send_request(MODE_TICK, $urandom, $urandom_range(99) < abort_pct);
  endtask

  task automatic finish_cell();
    while (seq_phase != PH_IDLE) send_request(MODE_TICK, $urandom, 1'b0);
  endtask

  // load one pattern and tick it through, with a stray load now and then
  task automatic run_cell(logic [NUM_DOTS-1:0] pat, int unsigned abort_pct);
    int unsigned guard;
    send_request(MODE_LOAD, pat, $urandom_range(1));
    guard = 0;
    while (seq_phase != PH_IDLE && guard < 4000) begin
      if ($urandom_range(49) == 0) send_request(MODE_LOAD, $urandom, $urandom_range(1));
      else send_request(MODE_TICK, $urandom, $urandom_range(99) < abort_pct);
      guard++;
    end
    if ($urandom_range(3) == 0) send_request(MODE_TICK, $urandom, $urandom_range(1));
  endtask

  task automatic shuffle_timing();
    write_reg(REG_RETRACT, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4));
    write_reg(REG_FIRST_POP, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5));
    write_reg(REG_POP_PER, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3));
    write_reg(REG_PWM_PERIOD, ($urandom_range(9) == 0) ? $urandom_range(1) :
              (($urandom_range(9) == 0) ? $urandom_range(11, 30) : $urandom_range(2, 10)));
    write_reg(REG_PWM_ON, $urandom_range(12));
    write_reg(REG_HOLD, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40));
    write_reg(REG_BLANK, $urandom_range(5));
    write_reg(REG_STAGGER, $urandom_range(7));
  endtask

  // idle coasting, a load at reset timing, a rejected load, retune mid-cell
  task automatic test_idle_defaults();
    send_request(MODE_TICK, DOT_MASK, 1'b1);
    send_request(MODE_TICK, '0, 1'b0);
    send_request(MODE_LOAD, 6'b100101, 1'b0);
    tick_run(3, 0);
    send_request(MODE_LOAD, DOT_MASK, 1'b1);
    set_timing(1, 1, 1, 2, 1, 1, 0, 3);
    finish_cell();
  endtask

  task automatic test_short_cells();
    run_cell('0, 0);
    write_reg(REG_BLANK, 2);
    run_cell('0, 0);
    run_cell(DOT_MASK, 0);
    run_cell(6'b000001, 0);
    run_cell(6'b100000, 0);
    // on time above the period, long hold ended by the button
    set_timing(2, 3, 2, 4, 6, 200, 1, 6);
    run_cell(6'b101101, 50);
  endtask

  task automatic test_zero_settings();
    set_timing(0, 0, 0, 0, 0, 0, 0, 0);
    run_cell(6'b011011, 0);
    write_reg(REG_PWM_PERIOD, 1);
    write_reg(REG_STAGGER, 7);
    run_cell(DOT_MASK, 20);
    run_cell('0, 0);
  endtask

  // full-scale timing, pulled back one register at a time while the cell runs
  task automatic test_full_scale();
    set_timing(24'hFFFFFF, 24'hFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 7);
    send_request(MODE_LOAD, DOT_MASK, 1'b0);
    tick_run(6, 50);
    write_reg(REG_RETRACT, 1);
    tick_run(4, 0);
    write_reg(REG_FIRST_POP, 1);
    tick_run(6, 0);
    write_reg(REG_PWM_PERIOD, 2);
    write_reg(REG_POP_PER, 1);
    while (seq_phase == PH_POP) send_request(MODE_TICK, $urandom, 1'b0);
    tick_run(4, 0);
    write_reg(REG_STAGGER, 0);
    tick_run(4, 0);
    write_reg(REG_STAGGER, 7);
    write_reg(REG_HOLD, 1);
    finish_cell();
    send_request(MODE_LOAD, '0, 1'b1);
    tick_run(6, 0);
    write_reg(REG_BLANK, 1);
    finish_cell();
  endtask

  task automatic test_random_cells();
    int unsigned         stop_at;
    int unsigned         abort_pct;
    logic [NUM_DOTS-1:0] pat;
    stop_at = items_sent + 1400;
    while (items_sent < stop_at) begin
      if ($urandom_range(2) == 0) shuffle_timing();
      case ($urandom_range(9))
        0: pat = '0;
        1: pat = DOT_MASK;
        default: pat = $urandom;
      endcase
      case ($urandom_range(2))
        0: abort_pct = 0;
        1: abort_pct = 3;
        default: abort_pct = 25;
      endcase
      run_cell(pat, abort_pct);
    end
  endtask

  initial begin
    restore_defaults();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_defaults();
    test_short_cells();
    test_zero_settings();
    test_full_scale();
    test_random_cells();
    settle_block();
    if (pending_drive.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_drive.size()));
    repeat (16) @(posedge clk);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
